// ----- sv/assert_macros.svh -----
// assertion helpers included by the rotation unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/erm_pkg.sv -----
// ----------------------------------------------------------------------------
// erm_pkg
// constants, types and helpers for the euler rotation matrix unit
// ----------------------------------------------------------------------------
package erm_pkg;

    localparam int CORDIC_STEPS_DEF = 14;
    localparam int VECTOR_WIDTH_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;

    localparam logic signed [17:0] ANG_PI      = 18'sd12868;
    localparam logic signed [17:0] ANG_HALF_PI = 18'sd6434;
    localparam logic signed [17:0] ANG_TWO_PI  = 18'sd25736;
    localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    typedef logic signed [15:0] q14_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CANON,
        ST_WRAP,
        ST_CORDIC_LOAD,
        ST_CORDIC_RUN,
        ST_CORDIC_DONE,
        ST_MAT,
        ST_ROT,
        ST_OUT
    } state_t;

    function automatic logic signed [19:0] atan_q16(input logic [4:0] i);
        logic signed [19:0] r;
        begin
            case (i)
                5'd0:    r = 20'sd51472;
                5'd1:    r = 20'sd30385;
                5'd2:    r = 20'sd16055;
                5'd3:    r = 20'sd8150;
                5'd4:    r = 20'sd4091;
                5'd5:    r = 20'sd2047;
                5'd6:    r = 20'sd1024;
                5'd7:    r = 20'sd512;
                5'd8:    r = 20'sd256;
                5'd9:    r = 20'sd128;
                5'd10:   r = 20'sd64;
                5'd11:   r = 20'sd32;
                5'd12:   r = 20'sd16;
                5'd13:   r = 20'sd8;
                5'd14:   r = 20'sd4;
                5'd15:   r = 20'sd2;
                5'd16:   r = 20'sd1;
                default: r = 20'sd0;
            endcase
            return r;
        end
    endfunction

    // move an angle one turn toward [-pi, pi), unchanged when already inside
    function automatic logic signed [17:0] wrap_pi(input logic signed [17:0] a);
        logic signed [17:0] r;
        begin
            r = a;
            if (a >= ANG_PI)
                r = a - ANG_TWO_PI;
            else if (a < -ANG_PI)
                r = a + ANG_TWO_PI;
            return r;
        end
    endfunction

    // round half up by 2^s and clamp to [-1, 1] in q1.14
    function automatic q14_t to_q14(input logic signed [47:0] v, input logic [4:0] s);
        logic signed [47:0] r;
        begin
            r = (v + (48'sd1 <<< (s - 5'd1))) >>> s;
            if (r > 48'sd16384)
                r = 48'sd16384;
            if (r < -48'sd16384)
                r = -48'sd16384;
            return r[15:0];
        end
    endfunction

endpackage

// ----- sv/erm_if.sv -----
// ----------------------------------------------------------------------------
// erm_in_if / erm_out_if
// valid/ready channels of the rotation unit
// ----------------------------------------------------------------------------
interface erm_in_if #(parameter int VW = 16);
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic signed [15:0]   heading_angle;
    logic signed [15:0]   pitch_angle;
    logic signed [15:0]   bank_angle;
    logic signed [VW-1:0] vec_x;
    logic signed [VW-1:0] vec_y;
    logic signed [VW-1:0] vec_z;
    modport source (output valid, kind, heading_angle, pitch_angle, bank_angle,
                    vec_x, vec_y, vec_z, input ready);
    modport sink (input valid, kind, heading_angle, pitch_angle, bank_angle,
                  vec_x, vec_y, vec_z, output ready);
endinterface

interface erm_out_if #(parameter int VW = 16);
    logic               valid;
    logic               ready;
    logic signed [VW:0] rot_x;
    logic signed [VW:0] rot_y;
    logic signed [VW:0] rot_z;
    modport source (output valid, rot_x, rot_y, rot_z, input ready);
    modport sink (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

// ----- sv/euler_rotation_matrix_rotate_unit.sv -----
// ----------------------------------------------------------------------------
// euler_rotation_matrix_rotate_unit
// heading/pitch/bank to rotation matrix, and vector rotation by it
// ----------------------------------------------------------------------------
// One item at a time; the unit is not ready while it works on one. A
// set-orientation item puts its angles in canonical form, then steps
// heading and bank by whole turns until both lie in [-pi, pi), runs one
// shared cordic stage for heading, pitch and bank (CORDIC_STEPS capped at
// 24) and builds the nine matrix entries on one shared 32x32 multiplier. A
// rotate item uses the same multiplier (one product per cycle into three
// accumulators), then rounds and saturates the sums into the output
// register. A result still waiting in the output register holds a
// following rotate item at its rounding step. The matrix resets to
// identity.
module euler_rotation_matrix_rotate_unit
    import erm_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int VECTOR_WIDTH = VECTOR_WIDTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    erm_in_if.sink    in_ch,
    erm_out_if.source out_ch
);
    `include "assert_macros.svh"

    localparam int NSTEP = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int VW = VECTOR_WIDTH;
    localparam int AW = VW + 18;

    state_t state_reg, state_next;

    q14_t mat_reg [9];
    logic signed [17:0] h_reg, p_reg, b_reg;
    logic signed [VW-1:0] vx_reg, vy_reg, vz_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [19:0] cz_reg;
    logic [4:0] step_reg;
    logic [1:0] ang_sel_reg;
    logic neg_reg;
    q14_t sin_reg [3];
    q14_t cos_reg [3];
    logic [3:0] idx_reg;
    logic signed [AW-1:0] acc_reg [3];
    logic signed [VW:0] rx_reg, ry_reg, rz_reg;
    logic out_valid_reg;
    // products kept for the matrix: cc=ch*cb, ss=sh*sb, cs=ch*sb, sc=sh*cb (q28)
    logic signed [31:0] cc_reg, ss_reg, cs_reg, sc_reg;
    logic out_load;
    logic angles_wrapped;

    function automatic logic signed [VW:0] sat_out(input logic signed [AW-1:0] s);
        logic signed [AW-1:0] r;
        begin
            r = (s + AW'(8192)) >>> 14;
            if (r > AW'((64'sd1 <<< VW) - 1))
                r = AW'((64'sd1 <<< VW) - 1);
            if (r < -AW'(64'sd1 <<< VW))
                r = -AW'(64'sd1 <<< VW);
            return r[VW:0];
        end
    endfunction

    // rounding step may load the output register when it is free or draining
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ch.ready);
    assign angles_wrapped = (h_reg >= -ANG_PI) && (h_reg < ANG_PI) &&
                            (b_reg >= -ANG_PI) && (b_reg < ANG_PI);

    // ---------------- state sequencing ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_ch.valid)
                    state_next = in_ch.kind ? ST_ROT : ST_CANON;
            ST_CANON:       state_next = ST_WRAP;
            ST_WRAP:
                if (angles_wrapped)
                    state_next = ST_CORDIC_LOAD;
            ST_CORDIC_LOAD: state_next = ST_CORDIC_RUN;
            ST_CORDIC_RUN:
                if (step_reg == 5'(NSTEP - 1))
                    state_next = ST_CORDIC_DONE;
            ST_CORDIC_DONE:
                state_next = (ang_sel_reg == 2'd2) ? ST_MAT : ST_CORDIC_LOAD;
            ST_MAT:
                if (idx_reg == 4'd11)
                    state_next = ST_IDLE;
            ST_ROT:
                if (idx_reg == 4'd9)
                    state_next = ST_OUT;
            ST_OUT:
                if (out_load)
                    state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE);
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.rot_x = rx_reg;
    assign out_ch.rot_y = ry_reg;
    assign out_ch.rot_z = rz_reg;

    // ---------------- canonical angles ----------------
    // pitch needs at most one turn; heading and bank are wrapped in ST_WRAP
    logic signed [17:0] cp, ch, cb;
    always_comb
    begin
        cp = wrap_pi(p_reg);
        ch = h_reg;
        cb = b_reg;
        if (cp < -ANG_HALF_PI)
        begin
            cp = -ANG_PI - cp;
            ch = ch + ANG_PI;
            cb = cb + ANG_PI;
        end
        else if (cp > ANG_HALF_PI)
        begin
            cp = ANG_PI - cp;
            ch = ch + ANG_PI;
            cb = cb + ANG_PI;
        end
        if (cp >= ANG_HALF_PI || cp <= -ANG_HALF_PI)
        begin
            ch = ch + cb;
            cb = '0;
        end
    end

    // ---------------- cordic stage ----------------
    logic signed [17:0] ang_cur, ang_fold;
    logic neg_fold;
    logic signed [33:0] sx, sy;
    logic signed [47:0] xsel, ysel;
    always_comb
    begin
        case (ang_sel_reg)
            2'd0:    ang_cur = h_reg;
            2'd1:    ang_cur = p_reg;
            default: ang_cur = b_reg;
        endcase
        ang_fold = ang_cur;
        neg_fold = 1'b0;
        if (ang_cur > ANG_HALF_PI)
        begin
            ang_fold = ang_cur - ANG_PI;
            neg_fold = 1'b1;
        end
        else if (ang_cur < -ANG_HALF_PI)
        begin
            ang_fold = ang_cur + ANG_PI;
            neg_fold = 1'b1;
        end
        sx = cx_reg >>> step_reg;
        sy = cy_reg >>> step_reg;
        xsel = 48'(cx_reg);
        ysel = 48'(cy_reg);
    end

    q14_t sh, chv, sp, cpv, sb, cbv;
    always_comb
    begin
        sh = sin_reg[0]; chv = cos_reg[0];
        sp = sin_reg[1]; cpv = cos_reg[1];
        sb = sin_reg[2]; cbv = cos_reg[2];
    end

    // ---------------- shared multiplier operands ----------------
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_MAT)
        begin
            // idx 0..3 cross products, 4..7 products with cos pitch,
            // 8..11 cross products times sin pitch
            case (idx_reg) inside
                4'd0, 4'd2, 4'd7: mul_a = 32'(chv);
                4'd1, 4'd3, 4'd4: mul_a = 32'(sh);
                4'd5:             mul_a = 32'(sb);
                4'd6:             mul_a = 32'(cbv);
                4'd8:             mul_a = ss_reg;
                4'd9:             mul_a = sc_reg;
                4'd10:            mul_a = cs_reg;
                4'd11:            mul_a = cc_reg;
                default:          mul_a = '0;
            endcase
            case (idx_reg) inside
                4'd0, 4'd3:    mul_b = 32'(cbv);
                4'd1, 4'd2:    mul_b = 32'(sb);
                [4'd4:4'd7]:   mul_b = 32'(cpv);
                [4'd8:4'd11]:  mul_b = 32'(sp);
                default:       mul_b = '0;
            endcase
        end
        else if (state_reg == ST_ROT)
        begin
            case (idx_reg) inside
                4'd0, 4'd1, 4'd2: mul_b = 32'(vx_reg);
                4'd3, 4'd4, 4'd5: mul_b = 32'(vy_reg);
                default:          mul_b = 32'(vz_reg);
            endcase
            mul_a = (idx_reg < 4'd9) ? 32'(mat_reg[idx_reg]) : '0;
        end
        mul_p = mul_a * mul_b;
    end

    logic signed [47:0] m_val;
    always_comb
    begin
        case (idx_reg)
            4'd8:    m_val = (48'(cc_reg) <<< 14) + mul_p[47:0];
            4'd9:    m_val = -(48'(cs_reg) <<< 14) + mul_p[47:0];
            4'd10:   m_val = -(48'(sc_reg) <<< 14) + mul_p[47:0];
            4'd11:   m_val = (48'(ss_reg) <<< 14) + mul_p[47:0];
            default: m_val = '0;
        endcase
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
                mat_reg[i] <= (i == 0 || i == 4 || i == 8) ? ONE_Q14 : '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (in_ch.valid)
                    begin
                        h_reg  <= 18'(in_ch.heading_angle);
                        p_reg  <= 18'(in_ch.pitch_angle);
                        b_reg  <= 18'(in_ch.bank_angle);
                        vx_reg <= in_ch.vec_x;
                        vy_reg <= in_ch.vec_y;
                        vz_reg <= in_ch.vec_z;
                        idx_reg <= '0;
                        ang_sel_reg <= '0;
                        for (int i = 0; i < 3; i++)
                            acc_reg[i] <= '0;
                    end
                ST_CANON:
                begin
                    h_reg <= ch;
                    p_reg <= cp;
                    b_reg <= cb;
                end
                ST_WRAP:
                begin
                    h_reg <= wrap_pi(h_reg);
                    b_reg <= wrap_pi(b_reg);
                end
                ST_CORDIC_LOAD:
                begin
                    cx_reg   <= GAIN_Q30;
                    cy_reg   <= '0;
                    cz_reg   <= 20'(ang_fold) <<< 4;
                    neg_reg  <= neg_fold;
                    step_reg <= '0;
                end
                ST_CORDIC_RUN:
                begin
                    if (!cz_reg[19])
                    begin
                        cx_reg <= cx_reg - sy;
                        cy_reg <= cy_reg + sx;
                        cz_reg <= cz_reg - atan_q16(step_reg);
                    end
                    else
                    begin
                        cx_reg <= cx_reg + sy;
                        cy_reg <= cy_reg - sx;
                        cz_reg <= cz_reg + atan_q16(step_reg);
                    end
                    step_reg <= step_reg + 5'd1;
                end
                ST_CORDIC_DONE:
                begin
                    cos_reg[ang_sel_reg] <= neg_reg ? -to_q14(xsel, 5'd16) : to_q14(xsel, 5'd16);
                    sin_reg[ang_sel_reg] <= neg_reg ? -to_q14(ysel, 5'd16) : to_q14(ysel, 5'd16);
                    ang_sel_reg <= ang_sel_reg + 2'd1;
                end
                ST_MAT:
                begin
                    idx_reg <= idx_reg + 4'd1;
                    case (idx_reg)
                        4'd0:  cc_reg <= mul_p[31:0];
                        4'd1:  ss_reg <= mul_p[31:0];
                        4'd2:  cs_reg <= mul_p[31:0];
                        4'd3:  sc_reg <= mul_p[31:0];
                        4'd4:  mat_reg[2] <= to_q14(mul_p[47:0], 5'd14);
                        4'd5:  mat_reg[3] <= to_q14(mul_p[47:0], 5'd14);
                        4'd6:  mat_reg[4] <= to_q14(mul_p[47:0], 5'd14);
                        4'd7:
                        begin
                            mat_reg[8] <= to_q14(mul_p[47:0], 5'd14);
                            mat_reg[5] <= -sp;
                        end
                        4'd8:  mat_reg[0] <= to_q14(m_val, 5'd28);
                        4'd9:  mat_reg[1] <= to_q14(m_val, 5'd28);
                        4'd10: mat_reg[6] <= to_q14(m_val, 5'd28);
                        4'd11: mat_reg[7] <= to_q14(m_val, 5'd28);
                        default: ;
                    endcase
                end
                ST_ROT:
                begin
                    idx_reg <= idx_reg + 4'd1;
                    if (idx_reg < 4'd9)
                    begin
                        // entries m0..m8: column of index mod 3 is the output
                        case (idx_reg) inside
                            4'd0, 4'd3, 4'd6: acc_reg[0] <= acc_reg[0] + AW'(mul_p);
                            4'd1, 4'd4, 4'd7: acc_reg[1] <= acc_reg[1] + AW'(mul_p);
                            default:          acc_reg[2] <= acc_reg[2] + AW'(mul_p);
                        endcase
                    end
                end
                ST_OUT:
                    if (out_load)
                    begin
                        rx_reg <= sat_out(acc_reg[0]);
                        ry_reg <= sat_out(acc_reg[1]);
                        rz_reg <= sat_out(acc_reg[2]);
                    end
                default: ;
            endcase
        end
    end

    `ASSERT_NEXT(a_out_after_rot, clk, rst_n, state_reg == ST_OUT, out_valid_reg)
    `ASSERT_IMPL(a_busy_not_ready, clk, rst_n, state_reg != ST_IDLE, !in_ch.ready)
    `ASSERT_IMPL(a_step_bound, clk, rst_n, state_reg == ST_CORDIC_RUN,
                 step_reg < 5'(NSTEP))
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_reg && !out_ch.ready, out_valid_reg)
endmodule
